### hdl/plid_pkg.sv
// Shared types and codes for the positional list unit.
// Used by the cell, the top level and the checker; no dependencies.
`timescale 1ns / 1ps

package plid_pkg;

    localparam int unsigned DATA_W     = 32;
    localparam int unsigned POS_W      = 5;
    localparam int unsigned CNT_OUT_W  = 5;
    localparam int unsigned ACT_W      = 2;
    localparam int unsigned STAT_W     = 2;
    // wide enough for any index or count up to the largest capacity
    localparam int unsigned IDX_W      = 7;
    localparam int unsigned CAPACITY_D = 16;

    localparam logic [ACT_W-1:0] ACT_INSERT   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ_FWD = 2'd2;
    localparam logic [ACT_W-1:0] ACT_READ_BWD = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROT_FWD,
        CELL_ROT_BWD
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [IDX_W-1:0]  pos;
        logic [IDX_W-1:0]  count;
        logic [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

### hdl/plid_cell.sv
// One entry of the list chain: holds a value and takes its next value from
// itself, its neighbors, the insert value or the wrap bus. Uses plid_pkg.
`timescale 1ns / 1ps

module plid_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic                       i_clk,
    input  plid_pkg::t_cell_ctl        i_ctl,
    input  logic [plid_pkg::DATA_W-1:0] i_left,
    input  logic [plid_pkg::DATA_W-1:0] i_right,
    input  logic [plid_pkg::DATA_W-1:0] i_wrap,
    output logic [plid_pkg::DATA_W-1:0] o_data,
    output logic                       o_is_tail
);
    import plid_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(IDX);
    localparam logic [IDX_W-1:0] MY_NEXT = IDX_W'(IDX + 1);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            CELL_INSERT: begin
                if (MY_IDX == i_ctl.pos) begin
                    n_data = i_ctl.value;
                end else if (MY_IDX > i_ctl.pos) begin
                    n_data = i_left;
                end
            end
            CELL_DELETE: begin
                if (MY_IDX >= i_ctl.pos) begin
                    n_data = i_right;
                end
            end
            CELL_ROT_FWD: begin
                if (MY_NEXT < i_ctl.count) begin
                    n_data = i_right;
                end else if (MY_NEXT == i_ctl.count) begin
                    n_data = i_wrap;
                end
            end
            CELL_ROT_BWD: begin
                // the head cell's left input is the wrap bus
                if (MY_IDX < i_ctl.count) begin
                    n_data = i_left;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data    = r_data;
    assign o_is_tail = (MY_NEXT == i_ctl.count);

endmodule

### hdl/positional_list_insert_delete_unit.sv
// Positional list unit: a chain of plid_cell entries with the sequencer.
// Depends on plid_pkg and plid_cell.
`timescale 1ns / 1ps

// Keeps an ordered list of up to CAPACITY signed 32-bit values, one per cell
// of a chain. Insert and delete shift the cells and give one result in the
// cycle after the input transfer; the next input is taken as soon as the
// output register is free. A forward or backward read rotates the used part
// of the chain by one cell per cycle and emits one entry per cycle while the
// output register is free, so a read holds the unit until its last entry is
// emitted (an empty list gives a single ST_EMPTY result), and the chain ends
// in its original order. No input is taken during a read. entry_count shows
// the low 5 bits of the count.
module positional_list_insert_delete_unit #(
    parameter int unsigned CAPACITY = plid_pkg::CAPACITY_D
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [plid_pkg::ACT_W-1:0]     i_action,
    input  logic [plid_pkg::POS_W-1:0]     i_position,
    input  logic signed [plid_pkg::DATA_W-1:0] i_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [plid_pkg::STAT_W-1:0]    o_status,
    output logic signed [plid_pkg::DATA_W-1:0] o_data,
    output logic [plid_pkg::CNT_OUT_W-1:0] o_entry_count,
    output logic                          o_last
);
    import plid_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] CAP_X = IDX_W'(CAPACITY);

    typedef enum logic {S_IDLE, S_READ} t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_left, n_left;
    logic               r_dir_fwd, n_dir_fwd;
    logic               r_o_valid, n_o_valid;
    logic [STAT_W-1:0]  r_status, n_status;
    logic [DATA_W-1:0]  r_data, n_data;
    logic [CW-1:0]      r_cnt_out, n_cnt_out;
    logic               r_last, n_last;

    t_cell_ctl          w_ctl;
    logic [DATA_W-1:0]  w_cell [CAPACITY];
    logic [CAPACITY-1:0] w_tail_sel;
    logic [DATA_W-1:0]  w_tail;
    logic [DATA_W-1:0]  w_wrap;
    logic [IDX_W-1:0]   w_pos;
    logic [IDX_W-1:0]   w_cnt;
    logic               w_out_free;
    logic               w_in_xfer;

    assign w_out_free = !r_o_valid || i_ready;
    assign o_ready    = (r_state == S_IDLE) && w_out_free;
    assign w_in_xfer  = i_valid && o_ready;
    assign w_pos      = IDX_W'(i_position);
    assign w_cnt      = IDX_W'(r_count);

    // one-hot pick of the tail cell
    always_comb begin
        w_tail = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_tail = w_tail | (w_cell[k] & {DATA_W{w_tail_sel[k]}});
        end
    end

    assign w_wrap = (w_ctl.op == CELL_ROT_FWD) ? w_cell[0] : w_tail;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_left    = r_left;
        n_dir_fwd = r_dir_fwd;
        n_o_valid = r_o_valid && !i_ready;
        n_status  = r_status;
        n_data    = r_data;
        n_cnt_out = r_cnt_out;
        n_last    = r_last;
        w_ctl.op    = CELL_HOLD;
        w_ctl.pos   = w_pos;
        w_ctl.count = w_cnt;
        w_ctl.value = i_value;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_o_valid = 1'b1;
                    n_data    = '0;
                    n_last    = 1'b1;
                    n_status  = ST_OK;
                    case (i_action)
                        ACT_INSERT: begin
                            if (w_pos > w_cnt) begin
                                n_status = ST_BAD_INDEX;
                            end else if (w_cnt >= CAP_X) begin
                                n_status = ST_FULL;
                            end else begin
                                w_ctl.op = CELL_INSERT;
                                n_count  = r_count + 1'b1;
                            end
                        end
                        ACT_DELETE: begin
                            if (w_pos >= w_cnt) begin
                                n_status = ST_BAD_INDEX;
                            end else begin
                                w_ctl.op = CELL_DELETE;
                                n_count  = r_count - 1'b1;
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                // results come from the read state
                                n_o_valid = 1'b0;
                                n_state   = S_READ;
                                n_left    = r_count;
                                n_dir_fwd = (i_action == ACT_READ_FWD);
                            end
                        end
                    endcase
                    n_cnt_out = n_count;
                end
            end
            S_READ: begin
                if (w_out_free) begin
                    w_ctl.op  = r_dir_fwd ? CELL_ROT_FWD : CELL_ROT_BWD;
                    n_o_valid = 1'b1;
                    n_status  = ST_OK;
                    n_data    = r_dir_fwd ? w_cell[0] : w_tail;
                    n_cnt_out = r_count;
                    n_last    = (r_left == CW'(1));
                    n_left    = r_left - 1'b1;
                    if (r_left == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_left    <= '0;
            r_dir_fwd <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_left    <= n_left;
            r_dir_fwd <= n_dir_fwd;
            r_o_valid <= n_o_valid;
        end
        r_status  <= n_status;
        r_data    <= n_data;
        r_cnt_out <= n_cnt_out;
        r_last    <= n_last;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;
        if (g == 0) begin : g_head
            assign w_left = w_wrap;
        end else begin : g_mid
            assign w_left = w_cell[g-1];
        end
        if (g == CAPACITY - 1) begin : g_end
            assign w_right = w_cell[g];
        end else begin : g_inner
            assign w_right = w_cell[g+1];
        end
        plid_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_left   (w_left),
            .i_right  (w_right),
            .i_wrap   (w_wrap),
            .o_data   (w_cell[g]),
            .o_is_tail(w_tail_sel[g])
        );
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_status;
    assign o_data        = r_data;
    assign o_entry_count = CNT_OUT_W'(r_cnt_out);
    assign o_last        = r_last;

endmodule

### hdl/plid_chk.sv
// Port-level checks for the positional list unit, bound to the top level.
// Depends on plid_pkg.
`timescale 1ns / 1ps

module plid_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [plid_pkg::STAT_W-1:0]    o_status,
    input logic [plid_pkg::DATA_W-1:0]    o_data,
    input logic [plid_pkg::CNT_OUT_W-1:0] o_entry_count,
    input logic                          o_last
);
    import plid_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data) && $stable(o_last))
        else $error("stalled result changed");

    // only reads give more than one result, and they are all ok
    a_multi_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_status == ST_OK)
        else $error("non-final result with error status");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_last && o_data == '0)
        else $error("error result not single or carries data");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EMPTY |-> o_entry_count == '0)
        else $error("empty status with nonzero count");

    // count stays put across the results of one read
    a_read_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=> !o_valid || $stable(o_entry_count))
        else $error("count changed during a read");

endmodule

bind positional_list_insert_delete_unit plid_chk u_plid_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_status     (o_status),
    .o_data       (o_data),
    .o_entry_count(o_entry_count),
    .o_last       (o_last)
);

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for positional_list_insert_delete_unit: a directed table, then
// random insert, delete and read traffic under four phases of handshake idling.
// Depends on plid_pkg and the unit RTL.

module tb_top;
    import plid_pkg::*;

    localparam int unsigned CAP            = CAPACITY_D;
    localparam int unsigned STALL_LIMIT    = 3000;
    localparam int unsigned RAND_PER_PHASE = 100;
    localparam int unsigned DIR_ROWS       = 18;

    typedef struct {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] data;
        logic [CNT_OUT_W-1:0]     count;
        logic                     last;
    } t_list_result;

    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic [POS_W-1:0]         position;
        logic [DATA_W-1:0]        value;
        logic                     fill_first;
        logic                     typed;
        logic [STAT_W-1:0]        t_status;
        logic [CNT_OUT_W-1:0]     t_count;
    } t_dir_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic [ACT_W-1:0]              i_action;
    logic [POS_W-1:0]              i_position;
    logic signed [DATA_W-1:0]      i_value;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic [STAT_W-1:0]             o_status;
    logic signed [DATA_W-1:0]      o_data;
    logic [CNT_OUT_W-1:0]          o_entry_count;
    logic                          o_last;

    // shadow copy of the list contents, head at index 0
    logic signed [DATA_W-1:0] shadow_list[$];
    t_list_result             pending_results[$];
    int unsigned              mismatches = 0;
    int unsigned              idle_cycles = 0;
    int unsigned              src_idle_pct = 0;
    int unsigned              sink_stall_pct = 0;

    // fill_first rows are preceded by inserts until the list is full
    t_dir_row dir_table [DIR_ROWS] = '{
        '{ACT_READ_FWD, 5'd0,  32'h0000_0000, 1'b0, 1'b1, ST_EMPTY,     5'd0},
        '{ACT_READ_BWD, 5'd0,  32'h0000_0000, 1'b0, 1'b1, ST_EMPTY,     5'd0},
        '{ACT_DELETE,   5'd0,  32'h0000_0000, 1'b0, 1'b1, ST_BAD_INDEX, 5'd0},
        '{ACT_DELETE,   5'd31, 32'h0000_0000, 1'b0, 1'b1, ST_BAD_INDEX, 5'd0},
        '{ACT_INSERT,   5'd31, 32'h5a5a_5a5a, 1'b0, 1'b1, ST_BAD_INDEX, 5'd0},
        '{ACT_INSERT,   5'd0,  32'h7fff_ffff, 1'b0, 1'b1, ST_OK,        5'd1},
        '{ACT_INSERT,   5'd1,  32'h8000_0000, 1'b0, 1'b1, ST_OK,        5'd2},
        '{ACT_INSERT,   5'd0,  32'hffff_ffff, 1'b0, 1'b1, ST_OK,        5'd3},
        '{ACT_INSERT,   5'd1,  32'h0000_0000, 1'b0, 1'b1, ST_OK,        5'd4},
        '{ACT_READ_FWD, 5'd0,  32'h0000_0000, 1'b0, 1'b0, ST_OK,        5'd0},
        '{ACT_READ_BWD, 5'd0,  32'h0000_0000, 1'b0, 1'b0, ST_OK,        5'd0},
        '{ACT_DELETE,   5'd3,  32'h0000_0000, 1'b0, 1'b1, ST_OK,        5'd3},
        '{ACT_DELETE,   5'd0,  32'h0000_0000, 1'b0, 1'b1, ST_OK,        5'd2},
        '{ACT_INSERT,   5'd16, 32'h1234_5678, 1'b1, 1'b1, ST_FULL,      5'd16},
        '{ACT_INSERT,   5'd17, 32'h1234_5678, 1'b0, 1'b1, ST_BAD_INDEX, 5'd16},
        '{ACT_READ_BWD, 5'd0,  32'h0000_0000, 1'b0, 1'b0, ST_OK,        5'd0},
        '{ACT_DELETE,   5'd16, 32'h0000_0000, 1'b0, 1'b1, ST_BAD_INDEX, 5'd16},
        '{ACT_DELETE,   5'd15, 32'h0000_0000, 1'b0, 1'b1, ST_OK,        5'd15}
    };

    positional_list_insert_delete_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_position    (i_position),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_data        (o_data),
        .o_entry_count (o_entry_count),
        .o_last        (o_last)
    );

    always #5 i_clk = ~i_clk;

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    endtask

    function automatic void queue_result(logic [STAT_W-1:0] status,
                                         logic signed [DATA_W-1:0] data, logic last);
        t_list_result r;
        r.status = status;
        r.data   = data;
        r.count  = CNT_OUT_W'(shadow_list.size());
        r.last   = last;
        pending_results.push_back(r);
    endfunction

    // applies one accepted action to the shadow list and queues what it should emit
    function automatic void apply_list_action(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                                              logic signed [DATA_W-1:0] val);
        int unsigned n;
        int unsigned idx;
        n = shadow_list.size();
        case (act)
            ACT_INSERT: begin
                // index check comes before the full check
                if (pos > n) begin
                    queue_result(ST_BAD_INDEX, '0, 1'b1);
                end else if (n >= CAP) begin
                    queue_result(ST_FULL, '0, 1'b1);
                end else begin
                    shadow_list.insert(int'(pos), val);
                    queue_result(ST_OK, '0, 1'b1);
                end
            end
            ACT_DELETE: begin
                if (pos >= n) begin
                    queue_result(ST_BAD_INDEX, '0, 1'b1);
                end else begin
                    shadow_list.delete(int'(pos));
                    queue_result(ST_OK, '0, 1'b1);
                end
            end
            default: begin
                if (n == 0) begin
                    queue_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int unsigned i = 0; i < n; i++) begin
                        idx = (act == ACT_READ_FWD) ? i : n - 1 - i;
                        queue_result(ST_OK, shadow_list[idx], i + 1 == n);
                    end
                end
            end
        endcase
    endfunction

    task automatic send_item(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                             logic signed [DATA_W-1:0] val, logic typed,
                             logic [STAT_W-1:0] t_status, logic [CNT_OUT_W-1:0] t_count);
        t_list_result r;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_action   <= act;
        i_position <= pos;
        i_value    <= val;
        do @(posedge i_clk); while (!o_ready);
        apply_list_action(act, pos, val);
        if (typed) begin
            // hand-written expectation replaces the single predicted result
            r.status = t_status;
            r.data   = '0;
            r.count  = t_count;
            r.last   = 1'b1;
            pending_results[pending_results.size() - 1] = r;
        end
    endtask

    task automatic random_item(int unsigned step);
        int unsigned              n;
        int unsigned              pick;
        int unsigned              ins_w;
        logic [ACT_W-1:0]         act;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        n = shadow_list.size();
        // first half of a phase grows the list toward full, second half drains it
        ins_w = (step < RAND_PER_PHASE / 2) ? 60 : 25;
        pick = $urandom_range(0, 99);
        if (pick < ins_w) act = ACT_INSERT;
        else if (pick < 80) act = ACT_DELETE;
        else if (pick < 90) act = ACT_READ_FWD;
        else act = ACT_READ_BWD;

        if ($urandom_range(0, 99) < 12) pos = POS_W'($urandom_range(0, 31));
        else if (act == ACT_INSERT) pos = POS_W'($urandom_range(0, n));
        else if (act == ACT_DELETE && n > 0) pos = POS_W'($urandom_range(0, n - 1));
        else pos = POS_W'($urandom_range(0, 31));

        pick = $urandom_range(0, 99);
        if (pick < 4) val = 32'h7fff_ffff;
        else if (pick < 8) val = 32'h8000_0000;
        else if (pick < 10) val = '0;
        else val = $urandom();
        send_item(act, pos, val, 1'b0, ST_OK, '0);
    endtask

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("result with nothing pending", o_data, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) flag_mismatch("status", o_status, want.status);
                if (o_data !== want.data) flag_mismatch("data", o_data, want.data);
                if (o_entry_count !== want.count)
                    flag_mismatch("entry_count", o_entry_count, want.count);
                if (o_last !== want.last) flag_mismatch("last", o_last, want.last);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("positional_list_insert_delete_unit test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_action   = ACT_INSERT;
        i_position = '0;
        i_value    = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct   = 18;
        sink_stall_pct = 18;
        foreach (dir_table[r]) begin
            if (dir_table[r].fill_first) begin
                while (shadow_list.size() < CAP) begin
                    send_item(ACT_INSERT, POS_W'($urandom_range(0, shadow_list.size())),
                              $urandom(), 1'b0, ST_OK, '0);
                end
            end
            send_item(dir_table[r].action, dir_table[r].position, dir_table[r].value,
                      dir_table[r].typed, dir_table[r].t_status, dir_table[r].t_count);
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 55; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 55; end
                default: begin src_idle_pct = 18; sink_stall_pct = 18; end
            endcase
            for (int unsigned k = 0; k < RAND_PER_PHASE; k++) begin
                random_item(k);
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // room for any stray result after the last expected one
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("positional_list_insert_delete_unit test passed");
        end else begin
            $display("positional_list_insert_delete_unit test failed");
        end
        $finish;
    end

endmodule
